@@ rtl/lte_pkg.sv @@
// lte_pkg: shared types, controller states and helper functions for the text embedder
// used by lte_ctrl, lte_dp and lsb_text_embed; depends on nothing
`timescale 1ns / 1ps

package lte_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} lte_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [2:0] idx;
		logic       last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       has_work;
		logic [3:0] count;
		logic       out_free;
	} dp_sts_t;

	localparam logic [3:0] K_MIN = 4'd1;
	localparam logic [3:0] K_MAX = 4'd8;

	function automatic logic [3:0] clamp_k(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v < K_MIN) begin
			r = K_MIN;
		end else if (v > K_MAX) begin
			r = K_MAX;
		end
		return r;
	endfunction

	// number of chunks a character splits into
	function automatic logic [3:0] chunks_of(input logic [3:0] k);
		logic [3:0] r;
		unique case (k)
			4'd1:    r = 4'd8;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd3;
			4'd4:    r = 4'd2;
			4'd5:    r = 4'd2;
			4'd6:    r = 4'd2;
			4'd7:    r = 4'd2;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/lte_ctrl.sv @@
// lte_ctrl: state machine sequencing chunk emission for one character
// depends on lte_pkg; drives lte_dp through ctrl_cmd_t
`timescale 1ns / 1ps

module lte_ctrl import lte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	lte_state_t state_q, state_d;
	logic [2:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				idx_q <= 3'd0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.idx  = idx_q;
		cmd.last = (({1'b0, idx_q} + 4'd1) == sts.count);
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid && sts.has_work) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && cmd.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_emit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_RUN)
		else $error("emit outside run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> state_q == ST_IDLE)
		else $error("run continues after last chunk");

	a_hold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !sts.out_free |=> $stable(idx_q))
		else $error("chunk index moved while output blocked");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !cmd.load)
		else $error("word loaded during run");

endmodule

@@ rtl/lte_dp.sv @@
// lte_dp: input capture, chunk extraction, view scaling and output register
// depends on lte_pkg; commanded by lte_ctrl
`timescale 1ns / 1ps

module lte_dp import lte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_sts_t    sts,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic [7:0] text_char,
	input  logic [7:0] pixel_byte_0,
	input  logic [7:0] pixel_byte_1,
	input  logic [7:0] pixel_byte_2,
	input  logic [7:0] pixel_byte_3,
	input  logic [7:0] pixel_byte_4,
	input  logic [7:0] pixel_byte_5,
	input  logic [7:0] pixel_byte_6,
	input  logic [7:0] pixel_byte_7,
	input  logic [3:0] pixels_valid,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] stego_byte,
	output logic [7:0] bit_view_byte,
	output logic [2:0] chunk_index,
	output logic       last
);

	logic [3:0] k_q;
	logic [7:0] char_q;
	logic [7:0] pix_q [8];
	logic [3:0] count_q;
	logic       out_valid_q;
	logic [7:0] stego_q;
	logic [7:0] view_q;
	logic [2:0] idx_out_q;
	logic       last_q;

	logic [3:0]  limit;
	logic [3:0]  total;
	logic [3:0]  count_in;
	logic [7:0]  mask;
	logic [7:0]  span;
	logic [2:0]  ovr;
	logic [7:0]  chunk;
	logic [7:0]  stego;
	logic [15:0] wide;
	logic [7:0]  rep;
	logic [15:0] prod;
	logic [15:0] n255;
	logic [7:0]  view;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= K_MIN;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				k_q <= clamp_k(cfg_data);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q   <= text_char;
			pix_q[0] <= pixel_byte_0;
			pix_q[1] <= pixel_byte_1;
			pix_q[2] <= pixel_byte_2;
			pix_q[3] <= pixel_byte_3;
			pix_q[4] <= pixel_byte_4;
			pix_q[5] <= pixel_byte_5;
			pix_q[6] <= pixel_byte_6;
			pix_q[7] <= pixel_byte_7;
			count_q  <= count_in;
		end
		if (cmd.emit) begin
			stego_q   <= stego;
			view_q    <= view;
			idx_out_q <= cmd.idx;
			last_q    <= cmd.last;
		end
	end

	// chunk count for the word at the input
	always_comb begin
		limit    = (pixels_valid > 4'd8) ? 4'd8 : pixels_valid;
		total    = chunks_of(k_q);
		count_in = (total < limit) ? total : limit;
	end

	// chunk extraction and scaling
	always_comb begin
		mask  = 8'hFF >> (4'd8 - k_q);
		span  = ({4'd0, {1'b0, cmd.idx} + 4'd1}) * {4'd0, k_q};
		ovr   = 3'd0;
		chunk = 8'd0;
		if (span <= 8'd8) begin
			chunk = (char_q >> (4'd8 - span[3:0])) & mask;
		end else begin
			ovr   = span[2:0];
			chunk = ((mask >> ovr) & char_q) << ovr;
		end
		stego = (pix_q[cmd.idx] & ~mask) | chunk;

		// bit replication gives floor(256*c/m); one correction step gives floor(255*c/m)
		rep = 8'd0;
		for (int j = 1; j <= 8; j++) begin
			wide = {chunk, 8'h00} >> (j * int'(k_q));
			rep  = rep | wide[7:0];
		end
		wide = 16'd0;
		prod = {8'd0, rep} * {8'd0, mask};
		n255 = {chunk, 8'h00} - {8'd0, chunk};
		view = (prod > n255) ? (rep - 8'd1) : rep;
	end

	assign sts.has_work = (count_in != 4'd0);
	assign sts.count    = count_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign stego_byte    = stego_q;
	assign bit_view_byte = view_q;
	assign chunk_index   = idx_out_q;
	assign last          = last_q;

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q >= K_MIN && k_q <= K_MAX)
		else $error("significant bits out of range");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted word not presented");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit over an untaken word");

endmodule

@@ rtl/lsb_text_embed.sv @@
// lsb_text_embed: top level hiding one text character in up to eight cover bytes
// depends on lte_pkg, lte_ctrl and lte_dp
//
//  channel | handshake             | word
//  in      | in_valid / in_stall   | text_char, pixel_byte_0..7, pixels_valid
//  out     | out_valid / out_stall | stego_byte, bit_view_byte, chunk_index, last
//  cfg     | cfg_valid / cfg_ready | cfg_data (significant bits)
//
// an item is captured, then one chunk goes out per cycle while the output is not stalled
// count is min(ceil(8 / k), pixels_valid), computed in lte_dp when the item is captured
// the last result waits in the output register while the next item is taken
// out_stall holds the output register and pauses the sequencer
// arst_n clears the controller, output valid, and sets significant bits to 1
`timescale 1ns / 1ps

module lsb_text_embed import lte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_char,
	input  logic [7:0] pixel_byte_0,
	input  logic [7:0] pixel_byte_1,
	input  logic [7:0] pixel_byte_2,
	input  logic [7:0] pixel_byte_3,
	input  logic [7:0] pixel_byte_4,
	input  logic [7:0] pixel_byte_5,
	input  logic [7:0] pixel_byte_6,
	input  logic [7:0] pixel_byte_7,
	input  logic [3:0] pixels_valid,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] stego_byte,
	output logic [7:0] bit_view_byte,
	output logic [2:0] chunk_index,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	lte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lte_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.text_char     (text_char),
		.pixel_byte_0  (pixel_byte_0),
		.pixel_byte_1  (pixel_byte_1),
		.pixel_byte_2  (pixel_byte_2),
		.pixel_byte_3  (pixel_byte_3),
		.pixel_byte_4  (pixel_byte_4),
		.pixel_byte_5  (pixel_byte_5),
		.pixel_byte_6  (pixel_byte_6),
		.pixel_byte_7  (pixel_byte_7),
		.pixels_valid  (pixels_valid),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stego_byte    (stego_byte),
		.bit_view_byte (bit_view_byte),
		.chunk_index   (chunk_index),
		.last          (last)
	);

endmodule
